@@ hw/rtl/dnv_pkg.sv @@
// Shared types and constants for the domain name validator.
package dnv_pkg;

    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned MAP_WORDS   = 4;
    localparam int unsigned TOTAL_W     = 10;
    localparam int unsigned LABEL_W     = 8;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_MAP0      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP1      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP2      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP3      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TOTAL = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LABEL = 3'd5;

    localparam logic [CFG_DATA_W-1:0] MAP0_RESET = 64'd288054454291267584;
    localparam logic [CFG_DATA_W-1:0] MAP1_RESET = 64'd576460743847706622;
    localparam logic [CFG_DATA_W-1:0] MAP2_RESET = 64'd0;
    localparam logic [CFG_DATA_W-1:0] MAP3_RESET = 64'd0;
    localparam logic [TOTAL_W-1:0]    MAX_TOTAL_RESET = 10'd256;
    localparam logic [LABEL_W-1:0]    MAX_LABEL_RESET = 8'd64;

    localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
    localparam logic [7:0] CHAR_HYPHEN   = 8'h2D;
    localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;

    typedef struct packed {
        logic in_map;
        logic is_period;
        logic is_minus;
        logic is_digit;
        logic is_last;
    } byte_class_t;

endpackage

@@ hw/rtl/dnv_front.sv @@
// Front end: accept bytes, look them up in the acceptance map and classify them.
module dnv_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dnv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dnv_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          char_byte,
    input  logic                                is_last,
    output logic                                cls_valid,
    input  logic                                cls_ready,
    output dnv_pkg::byte_class_t                cls_word
);

    logic [dnv_pkg::CFG_DATA_W-1:0] map_reg [dnv_pkg::MAP_WORDS];
    logic                           stage_valid_reg;
    logic                           stage_valid_next;
    dnv_pkg::byte_class_t           stage_word_reg;
    dnv_pkg::byte_class_t           stage_word_next;
    logic                           take;

    assign in_ready  = !stage_valid_reg || cls_ready;
    assign take      = in_valid && in_ready;
    assign cls_valid = stage_valid_reg;
    assign cls_word  = stage_word_reg;

    always_comb
    begin
        stage_word_next.in_map    = map_reg[char_byte[7:6]][char_byte[5:0]];
        stage_word_next.is_period = (char_byte == dnv_pkg::CHAR_PERIOD);
        stage_word_next.is_minus  = (char_byte == dnv_pkg::CHAR_HYPHEN);
        stage_word_next.is_digit  =
            char_byte inside {[dnv_pkg::CHAR_DIGIT_LO:dnv_pkg::CHAR_DIGIT_HI]};
        stage_word_next.is_last   = is_last;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (cls_ready)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg[0]      <= dnv_pkg::MAP0_RESET;
            map_reg[1]      <= dnv_pkg::MAP1_RESET;
            map_reg[2]      <= dnv_pkg::MAP2_RESET;
            map_reg[3]      <= dnv_pkg::MAP3_RESET;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    dnv_pkg::REG_MAP0: map_reg[0] <= cfg_data;
                    dnv_pkg::REG_MAP1: map_reg[1] <= cfg_data;
                    dnv_pkg::REG_MAP2: map_reg[2] <= cfg_data;
                    dnv_pkg::REG_MAP3: map_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_word_reg <= stage_word_next;
        end
    end

endmodule

@@ hw/rtl/dnv_queue.sv @@
// Short queue of classified bytes between front and back.
module dnv_queue #(
    parameter int unsigned DEPTH = dnv_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  dnv_pkg::byte_class_t push_word,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output dnv_pkg::byte_class_t pop_word
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dnv_pkg::byte_class_t mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ hw/rtl/dnv_back.sv @@
// Back end: track name and label state, apply length and label rules, emit the verdict.
module dnv_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dnv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dnv_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            cls_valid,
    output logic                            cls_ready,
    input  dnv_pkg::byte_class_t            cls_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            accepted
);

    logic [dnv_pkg::TOTAL_W-1:0] max_total_reg;
    logic [dnv_pkg::LABEL_W-1:0] max_label_reg;
    logic [dnv_pkg::TOTAL_W-1:0] total_reg;
    logic [dnv_pkg::TOTAL_W-1:0] total_next;
    logic [dnv_pkg::LABEL_W-1:0] label_reg;
    logic [dnv_pkg::LABEL_W-1:0] label_next;
    logic                        digits_reg;
    logic                        digits_next;
    logic                        hyphen_reg;
    logic                        hyphen_next;
    logic                        failed_reg;
    logic                        failed_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        accepted_reg;
    logic                        accepted_next;
    logic [dnv_pkg::TOTAL_W-1:0] total_inc;
    logic [dnv_pkg::LABEL_W-1:0] label_inc;
    logic                        fail;
    logic                        take;

    // hold only a last byte while the previous verdict waits
    assign cls_ready = !out_valid_reg || out_ready || !cls_word.is_last;
    assign take      = cls_valid && cls_ready;
    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;

    always_comb
    begin
        total_inc   = (total_reg == '1) ? total_reg : total_reg + 1'b1;
        label_inc   = (label_reg == '1) ? label_reg : label_reg + 1'b1;
        fail        = (total_inc >= max_total_reg) || !cls_word.in_map;
        total_next  = total_inc;
        label_next  = '0;
        digits_next = 1'b1;
        hyphen_next = 1'b0;
        if (cls_word.is_period)
        begin
            if ((label_reg == '0) || hyphen_reg || cls_word.is_last)
            begin
                fail = 1'b1;
            end
        end
        else
        begin
            label_next  = label_inc;
            digits_next = digits_reg && cls_word.is_digit;
            hyphen_next = cls_word.is_minus;
            if ((label_reg == '0) && cls_word.is_minus)
            begin
                fail = 1'b1;
            end
            if (label_inc >= max_label_reg)
            begin
                fail = 1'b1;
            end
            if (cls_word.is_last && (cls_word.is_minus || digits_next))
            begin
                fail = 1'b1;
            end
        end
        failed_next    = failed_reg || fail;
        accepted_next  = accepted_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (take && cls_word.is_last)
        begin
            accepted_next  = !failed_next;
            out_valid_next = 1'b1;
            total_next     = '0;
            label_next     = '0;
            digits_next    = 1'b1;
            hyphen_next    = 1'b0;
            failed_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_total_reg <= dnv_pkg::MAX_TOTAL_RESET;
            max_label_reg <= dnv_pkg::MAX_LABEL_RESET;
            total_reg     <= '0;
            label_reg     <= '0;
            digits_reg    <= 1'b1;
            hyphen_reg    <= 1'b0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            accepted_reg  <= accepted_next;
            if (take)
            begin
                total_reg  <= total_next;
                label_reg  <= label_next;
                digits_reg <= digits_next;
                hyphen_reg <= hyphen_next;
                failed_reg <= failed_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    dnv_pkg::REG_MAX_TOTAL: max_total_reg <= cfg_data[dnv_pkg::TOTAL_W-1:0];
                    dnv_pkg::REG_MAX_LABEL: max_label_reg <= cfg_data[dnv_pkg::LABEL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ hw/rtl/domain_name_validator.sv @@
// Top level of the domain name validator: front end, queue and back end.
// Takes one byte of a domain name per word, with is_last on the final byte, and
// returns one accepted word per name. The front end checks each byte against the
// 256-bit acceptance map and registers its class, the byte passes a short
// queue, and the back end updates the length counters and label rules, so bytes
// are taken one per clock while in_ready is high. The verdict register is loaded
// once the last byte has passed the classify register and the queue.
// A verdict still waiting on out_ready holds back only the next last byte; other
// bytes keep flowing, and the queue and classify register absorb up to QUEUE_DEPTH
// plus one bytes before in_ready drops. Configuration writes land at the next clock
// edge and must be made while no name is in flight.
module domain_name_validator #(
    parameter int unsigned QUEUE_DEPTH = dnv_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dnv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dnv_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      char_byte,
    input  logic                            is_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            accepted
);

    logic                 front_valid;
    logic                 front_ready;
    dnv_pkg::byte_class_t front_word;
    logic                 back_valid;
    logic                 back_ready;
    dnv_pkg::byte_class_t back_word;

    dnv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_byte (char_byte),
        .is_last   (is_last),
        .cls_valid (front_valid),
        .cls_ready (front_ready),
        .cls_word  (front_word)
    );

    dnv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_word  (front_word),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_word   (back_word)
    );

    dnv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cls_valid (back_valid),
        .cls_ready (back_ready),
        .cls_word  (back_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .accepted  (accepted)
    );

endmodule
